FILE: hdl/tti_pkg.sv
// Package for the text to integer parser: character codes, base codes,
// and the types shared by the character decoder, input stage and parse core.
// No dependencies.
package tti_pkg;

    localparam int unsigned CH_W    = 16;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned BASE_W  = 5;

    // ASCII codes the parser reacts to.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_O  = 8'h6F;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // Base codes.
    localparam logic [BASE_W-1:0] BASE_AUTO = 5'd0;
    localparam logic [BASE_W-1:0] BASE_BIN  = 5'd2;
    localparam logic [BASE_W-1:0] BASE_OCT  = 5'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 5'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 5'd16;
    localparam logic [BASE_W-1:0] RADIX_RESET = BASE_DEC;

    // One input item as it sits in the input register.
    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            last;
        logic            empty_req;
    } t_item;

    // Classification of the low byte of a character.
    typedef struct packed {
        logic       is_nul;
        logic       is_minus;
        logic       is_plus;
        logic       pfx_hex;
        logic       pfx_oct;
        logic       pfx_bin;
        logic       is_digit;
        logic [3:0] digit;
    } t_char_info;

    function automatic logic base_valid(input logic [BASE_W-1:0] b);
        return (b == BASE_BIN) || (b == BASE_OCT) || (b == BASE_DEC) || (b == BASE_HEX);
    endfunction

    // Multiply by one of the legal bases with shifts and at most one add. An illegal
    // base gives an error, or zero for an empty request: its product is never shown.
    function automatic logic [VALUE_W-1:0] mul_base(input logic [VALUE_W-1:0] acc,
                                                    input logic [BASE_W-1:0]  b);
        logic [VALUE_W-1:0] prod;
        case (b)
            BASE_BIN: prod = acc << 1;
            BASE_OCT: prod = acc << 3;
            BASE_DEC: prod = (acc << 3) + (acc << 1);
            BASE_HEX: prod = acc << 4;
            default:  prod = acc;
        endcase
        return prod;
    endfunction

endpackage

FILE: hdl/tti_char_class.sv
// Character decoder for the text to integer parser: folds case and
// classifies the low byte of a character. Depends on tti_pkg.
module tti_char_class
    import tti_pkg::*;
(
    input  logic [CH_W-1:0] i_ch,
    output t_char_info      o_info
);

    logic [7:0] lo;
    logic [7:0] lc;
    logic [7:0] dec_off;
    logic [7:0] hex_off;
    logic       is_dec;
    logic       is_hex;

    assign lo = i_ch[7:0];
    assign lc = ((lo >= CH_UP_A) && (lo <= CH_UP_Z)) ? (lo | CASE_BIT) : lo;

    assign is_dec  = (lc >= CH_ZERO) && (lc <= CH_NINE);
    assign is_hex  = (lc >= CH_LO_A) && (lc <= CH_LO_F);
    assign dec_off = lc - CH_ZERO;
    assign hex_off = lc - CH_LO_A + 8'd10;

    always_comb begin
        o_info.is_nul   = (lo == CH_NUL);
        o_info.is_minus = (lo == CH_MINUS);
        o_info.is_plus  = (lo == CH_PLUS);
        o_info.pfx_hex  = (lc == CH_LO_X);
        o_info.pfx_oct  = (lc == CH_LO_O);
        o_info.pfx_bin  = (lc == CH_LO_B);
        o_info.is_digit = is_dec || is_hex;
        o_info.digit    = is_dec ? dec_off[3:0] : hex_off[3:0];
    end

endmodule

FILE: hdl/tti_in_stage.sv
// Input register of the text to integer parser: captures one transfer and
// holds it until the parse core takes it. Depends on tti_pkg.
module tti_in_stage
    import tti_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_take
);

    logic  r_valid;
    t_item r_item;

    // The register refills in the same cycle the core takes its content.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

FILE: hdl/tti_core.sv
// Parse core of the text to integer parser: string state, one-pass update
// per character, and the result register. Depends on tti_pkg, tti_char_class.
module tti_core
    import tti_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [BASE_W-1:0]  i_radix,
    input  logic               i_valid,
    input  t_item              i_item,
    output logic               o_take,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic [VALUE_W-1:0] o_value,
    output logic               o_status
);

    typedef enum logic [1:0] {
        PH_SIGN   = 2'd0,
        PH_PREFIX = 2'd1,
        PH_DIGITS = 2'd2
    } t_phase;

    t_phase             r_phase,    n_phase;
    logic               r_negative, n_negative;
    logic [VALUE_W-1:0] r_acc,      n_acc;
    logic [BASE_W-1:0]  r_base,     n_base;
    logic               r_halted,   n_halted;
    logic               r_res_valid;
    logic [VALUE_W-1:0] r_value,    n_value;
    logic               r_status,   n_status;

    t_char_info info;
    logic       yields;
    logic       out_free;

    tti_char_class u_class (
        .i_ch   (i_item.ch),
        .o_info (info)
    );

    assign yields   = i_item.empty_req || i_item.last;
    assign out_free = !r_res_valid || i_res_ready;
    assign o_take   = i_valid && (!yields || out_free);

    always_comb begin
        logic               start;
        logic               used;
        logic               run_pfx;
        logic               run_dig;
        t_phase             ph1;
        logic [BASE_W-1:0]  base0;
        logic               halt0;
        logic [VALUE_W-1:0] acc0;
        logic               ok;

        start   = (r_phase == PH_SIGN);
        base0   = start ? i_radix : r_base;
        halt0   = start ? 1'b0 : r_halted;
        acc0    = start ? '0 : r_acc;
        used    = start && (info.is_minus || info.is_plus);
        ph1     = start ? PH_PREFIX : r_phase;

        n_negative = start ? info.is_minus : r_negative;
        n_base     = base0;
        n_halted   = halt0;
        n_acc      = acc0;
        n_phase    = ph1;

        // Prefix step: with automatic base, choose it from this character.
        run_pfx = !used && !halt0 && (ph1 == PH_PREFIX);
        if (run_pfx) begin
            n_phase = PH_DIGITS;
            if (base0 == BASE_AUTO) begin
                if (info.is_nul) begin
                    n_halted = 1'b1;
                end else if (info.pfx_hex) begin
                    n_base = BASE_HEX;
                    used   = 1'b1;
                end else if (info.pfx_oct) begin
                    n_base = BASE_OCT;
                    used   = 1'b1;
                end else if (info.pfx_bin) begin
                    n_base = BASE_BIN;
                    used   = 1'b1;
                end else begin
                    n_base = BASE_DEC;
                end
            end
        end

        // Digit step: accumulate, or stop on anything that is not a digit of the base.
        run_dig = !used && !n_halted && (n_phase == PH_DIGITS);
        if (run_dig) begin
            if (!info.is_digit || ({1'b0, info.digit} >= n_base)) begin
                n_halted = 1'b1;
            end else begin
                n_acc = mul_base(acc0, n_base) + {{(VALUE_W-4){1'b0}}, info.digit};
            end
        end

        ok       = base_valid(n_base);
        n_status = !ok;
        n_value  = !ok ? '0 : (n_negative ? ('0 - n_acc) : n_acc);

        // Empty requests give a zero success result; they and string ends go idle.
        if (i_item.empty_req) begin
            n_status = 1'b0;
            n_value  = '0;
        end
        if (yields) begin
            n_phase    = PH_SIGN;
            n_negative = 1'b0;
            n_acc      = '0;
            n_base     = BASE_AUTO;
            n_halted   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SIGN;
            r_negative  <= 1'b0;
            r_acc       <= '0;
            r_base      <= BASE_AUTO;
            r_halted    <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_phase    <= n_phase;
                r_negative <= n_negative;
                r_acc      <= n_acc;
                r_base     <= n_base;
                r_halted   <= n_halted;
            end
            if (o_take && yields) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && yields) begin
            r_value  <= n_value;
            r_status <= n_status;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_value     = r_value;
    assign o_status    = r_status;

endmodule

FILE: hdl/text_to_integer_parser_unit.sv
// Top level of the text to integer parser: radix register, input stage and
// parse core. Depends on tti_pkg, tti_in_stage, tti_core.
//
// Channel   Direction  tdata                 tuser         tlast
// s_axis    in         [15:0] ch             [0] empty_req [0] last
// m_axis    out        [31:0] value          [0] status    -
// radix     in         i_radix_we + i_radix_wdata[4:0], no read-back
//
// A new transfer is taken every cycle while results drain. A character goes through the input
// register and the one-pass parse logic into the result register. The synchronous, active-low
// reset clears the string state, sets the radix to ten and empties both registers. A stall on
// m_axis holds the result; the first character that gives a result waits in the input register
// until it leaves. The radix is sampled on each string's first character.
module text_to_integer_parser_unit
    import tti_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration.
    input  logic                 i_radix_we,
    input  logic [BASE_W-1:0]    i_radix_wdata,
    // Character stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [CH_W-1:0]      s_axis_tdata,   // [15:0] ch
    input  logic                 s_axis_tlast,   // last
    input  logic                 s_axis_tuser,   // [0] empty_req
    // Result stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [VALUE_W-1:0]   m_axis_tdata,   // [31:0] value
    output logic                 m_axis_tuser    // [0] status
);

    logic [BASE_W-1:0] r_radix;
    t_item             in_item;
    t_item             st_item;
    logic              st_valid;
    logic              take;

    // The radix register is written whenever the enable is high.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_radix_we) begin
            r_radix <= i_radix_wdata;
        end
    end

    always_comb begin
        in_item.ch        = s_axis_tdata;
        in_item.last      = s_axis_tlast;
        in_item.empty_req = s_axis_tuser;
    end

    tti_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (st_valid),
        .o_item  (st_item),
        .i_take  (take)
    );

    tti_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_radix     (r_radix),
        .i_valid     (st_valid),
        .i_item      (st_item),
        .o_take      (take),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_value     (m_axis_tdata),
        .o_status    (m_axis_tuser)
    );

endmodule

FILE: hdl/tti_checker.sv
// Port-level checks for the text to integer parser, bound to the top level.
// Depends on tti_pkg and text_to_integer_parser_unit.
module tti_checker
    import tti_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               s_axis_tuser,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [VALUE_W-1:0] m_axis_tdata,
    input logic               m_axis_tuser
);

    // A stalled result holds still.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // An error result always carries a zero value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("error result with nonzero value");

    // With the result side free, the input side never pushes back.
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is free");

    // An accepted empty request, once the result side is free, gives a zero success result.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser)
            ##1 (!m_axis_tvalid || m_axis_tready) |=>
            m_axis_tvalid && m_axis_tdata == '0 && !m_axis_tuser)
        else $error("empty request result missing or wrong");

endmodule

bind text_to_integer_parser_unit tti_checker u_tti_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
